FILE: hw/rtl/voxel_occupancy_grid_assert.svh
// Assertion macros shared by the voxel occupancy grid RTL.
`ifndef VOXEL_OCCUPANCY_GRID_ASSERT_SVH
`define VOXEL_OCCUPANCY_GRID_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define VOG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define VOG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/vog_pkg.sv
// Shared constants and types of the voxel occupancy grid.
package vog_pkg;

    localparam int COORD_W   = 32;
    localparam int CELL_BITS = 4;
    localparam int CELL_W    = 3 * CELL_BITS;
    localparam int ROW_BITS  = 2 * CELL_BITS;
    localparam int ROW_W     = 1 << CELL_BITS;
    localparam int STEP_W    = (CELL_BITS > 1) ? $clog2(CELL_BITS) : 1;
    localparam int INDEX_W   = 12;
    localparam logic [CELL_BITS-1:0] CELL_TOP = '1;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_WIDEN = 2'd1,
        MODE_MARK  = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    // Control from the sequencer to the per-axis quotient units.
    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

endpackage

FILE: hw/rtl/vog_channels.sv
// Valid/ready channel interfaces for point input and grid results.
interface vog_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;

    modport source (output valid, mode, x_coord, y_coord, z_coord, input ready);
    modport sink   (input valid, mode, x_coord, y_coord, z_coord, output ready);
endinterface

interface vog_out_if;
    logic        valid;
    logic        ready;
    logic        overlap;
    logic        inside_box;
    logic [11:0] cell_index;

    modport source (output valid, overlap, inside_box, cell_index, input ready);
    modport sink   (input valid, overlap, inside_box, cell_index, output ready);
endinterface

FILE: hw/rtl/vog_axis_div.sv
// Bit-serial quotient unit: one axis cell, floor(2^CELL_BITS * d / e), clamped.
module vog_axis_div
    import vog_pkg::*;
(
    input  logic                 i_clk,
    input  t_div_ctl             i_ctl,
    input  logic [COORD_W:0]     i_num,
    input  logic [COORD_W-1:0]   i_den,
    output logic [CELL_BITS-1:0] o_q
);

    logic [COORD_W-1:0]   r_rem;
    logic [CELL_BITS-1:0] r_q;
    logic                 r_zero;
    logic                 r_sat;

    logic [COORD_W:0] rem2;
    logic [COORD_W:0] den_ext;
    logic [COORD_W:0] diff;
    logic             ge;
    logic             num_nonpos;

    assign rem2       = {r_rem, 1'b0};
    assign den_ext    = {1'b0, i_den};
    assign diff       = rem2 - den_ext;
    assign ge         = (rem2 >= den_ext);
    assign num_nonpos = i_num[COORD_W] || (i_num == '0);

    // A distance at or beyond the full extent saturates; otherwise d < e and
    // the restoring steps below produce exactly CELL_BITS quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem  <= i_num[COORD_W-1:0];
            r_q    <= '0;
            r_zero <= (i_den == '0) || num_nonpos;
            r_sat  <= (i_num[COORD_W-1:0] >= i_den);
        end else if (i_ctl.step) begin
            r_rem <= ge ? diff[COORD_W-1:0] : rem2[COORD_W-1:0];
            r_q   <= {r_q[CELL_BITS-2:0], ge};
        end
    end

    assign o_q = r_zero ? '0 : (r_sat ? CELL_TOP : r_q);

endmodule

FILE: hw/rtl/voxel_occupancy_grid.sv
// Voxel occupancy grid: bounding box, 16x16x16 cell map and overlap queries.
//
// Points arrive on i_in (mode, x/y/z signed coordinates) and each transfer
// produces exactly one result on o_out (overlap, inside_box, cell_index).
// Mode clear empties the map and the box; widen grows the box; mark sets the
// point's cell; query reports box membership and the cell's occupancy.
// A widen, mark or query item goes from its input transfer to its registered
// result through box update, differences, largest extent, quotient setup, the
// bit-serial quotient (one cell bit per cycle on all three axes in parallel),
// the cell map read and the result. A new item is not taken while one is in
// work: i_in.ready is high only while the sequencer is idle. The cell map is
// a 256 x 16 bit memory. After reset, and after every clear item, a clearing
// pass writes all 256 rows, one row per cycle, during which no input is taken;
// the clear item's result is registered once the output register is free,
// before the pass.
// The result sits in an output register, so a stalled receiver does not block
// the next item's work; only the final step waits for the register to empty.
`include "voxel_occupancy_grid_assert.svh"

module voxel_occupancy_grid
    import vog_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    vog_in_if.sink    i_in,
    vog_out_if.source o_out
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_BOX   = 9'b000000010,
        ST_EXT   = 9'b000000100,
        ST_MAX   = 9'b000001000,
        ST_PREP  = 9'b000010000,
        ST_DIV   = 9'b000100000,
        ST_READ  = 9'b001000000,
        ST_DONE  = 9'b010000000,
        ST_SWEEP = 9'b100000000
    } t_state;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CELL_BITS - 1);

    t_state r_state;
    t_state n_state;

    t_mode                     r_mode;
    logic signed [COORD_W-1:0] r_x, r_y, r_z;
    logic signed [COORD_W-1:0] r_min_x, r_min_y, r_min_z;
    logic signed [COORD_W-1:0] r_max_x, r_max_y, r_max_z;
    logic                      r_have;
    logic [COORD_W:0]          r_dx, r_dy, r_dz;
    logic [COORD_W-1:0]        r_ex, r_ey, r_ez;
    logic [COORD_W-1:0]        r_emax;
    logic                      r_inside;
    logic [STEP_W-1:0]         r_step;
    logic [ROW_BITS-1:0]       r_sweep;
    logic [CELL_W-1:0]         r_cell;
    logic [ROW_W-1:0]          r_row;

    logic                      r_out_valid;
    logic                      r_out_overlap;
    logic                      r_out_inside;
    logic [INDEX_W-1:0]        r_out_cell;

    logic [ROW_W-1:0]          r_map [ROW_W * ROW_W];

    t_div_ctl                  div_ctl;
    logic [CELL_BITS-1:0]      qx, qy, qz;
    logic [CELL_W-1:0]         cell_q;
    logic                      in_xfer;
    logic                      out_free;
    logic                      done_go;
    logic [ROW_BITS-1:0]       cell_row;
    logic [CELL_BITS-1:0]      cell_col;
    logic [ROW_W-1:0]          col_bit;
    logic [COORD_W:0]          ext_x, ext_y, ext_z;
    logic [COORD_W-1:0]        emax_xy;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign done_go    = (r_state == ST_DONE) && out_free;

    assign div_ctl.load = (r_state == ST_PREP);
    assign div_ctl.step = (r_state == ST_DIV);

    assign cell_q   = {qx, qy, qz};
    assign cell_row = r_cell[CELL_W-1:CELL_BITS];
    assign cell_col = r_cell[CELL_BITS-1:0];
    assign col_bit  = ROW_W'(1) << cell_col;

    assign ext_x   = {r_max_x[COORD_W-1], r_max_x} - {r_min_x[COORD_W-1], r_min_x};
    assign ext_y   = {r_max_y[COORD_W-1], r_max_y} - {r_min_y[COORD_W-1], r_min_y};
    assign ext_z   = {r_max_z[COORD_W-1], r_max_z} - {r_min_z[COORD_W-1], r_min_z};
    assign emax_xy = (r_ey > r_ex) ? r_ey : r_ex;

    vog_axis_div u_div_x (
        .i_clk (i_clk), .i_ctl (div_ctl), .i_num (r_dx), .i_den (r_emax), .o_q (qx)
    );
    vog_axis_div u_div_y (
        .i_clk (i_clk), .i_ctl (div_ctl), .i_num (r_dy), .i_den (r_emax), .o_q (qy)
    );
    vog_axis_div u_div_z (
        .i_clk (i_clk), .i_ctl (div_ctl), .i_num (r_dz), .i_den (r_emax), .o_q (qz)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (t_mode'(i_in.mode) == MODE_CLEAR) ? ST_DONE : ST_BOX;
                end
            end
            ST_BOX:  n_state = ST_EXT;
            ST_EXT:  n_state = ST_MAX;
            ST_MAX:  n_state = ST_PREP;
            ST_PREP: n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = (r_mode == MODE_CLEAR) ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (r_sweep == '1) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, the box and the output slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep     <= '0;
            r_step      <= '0;
            r_have      <= 1'b0;
            r_min_x     <= '0;
            r_min_y     <= '0;
            r_min_z     <= '0;
            r_max_x     <= '0;
            r_max_y     <= '0;
            r_max_z     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == ST_BOX && r_mode == MODE_WIDEN) begin
                r_have <= 1'b1;
                // The first point after reset or clear sets the box to itself.
                if (!r_have || r_x < r_min_x) r_min_x <= r_x;
                if (!r_have || r_x > r_max_x) r_max_x <= r_x;
                if (!r_have || r_y < r_min_y) r_min_y <= r_y;
                if (!r_have || r_y > r_max_y) r_max_y <= r_y;
                if (!r_have || r_z < r_min_z) r_min_z <= r_z;
                if (!r_have || r_z > r_max_z) r_max_z <= r_z;
            end

            if (r_state == ST_PREP) begin
                r_step <= '0;
            end else if (r_state == ST_DIV) begin
                r_step <= r_step + 1'b1;
            end

            if (r_state == ST_SWEEP) begin
                r_sweep <= r_sweep + 1'b1;
            end

            if (done_go) begin
                r_out_valid <= 1'b1;
                if (r_mode == MODE_CLEAR) begin
                    r_have  <= 1'b0;
                    r_min_x <= '0;
                    r_min_y <= '0;
                    r_min_z <= '0;
                    r_max_x <= '0;
                    r_max_y <= '0;
                    r_max_z <= '0;
                    r_sweep <= '0;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mode <= t_mode'(i_in.mode);
            r_x    <= i_in.x_coord;
            r_y    <= i_in.y_coord;
            r_z    <= i_in.z_coord;
        end
        if (r_state == ST_EXT) begin
            r_dx     <= {r_x[COORD_W-1], r_x} - {r_min_x[COORD_W-1], r_min_x};
            r_dy     <= {r_y[COORD_W-1], r_y} - {r_min_y[COORD_W-1], r_min_y};
            r_dz     <= {r_z[COORD_W-1], r_z} - {r_min_z[COORD_W-1], r_min_z};
            r_ex     <= ext_x[COORD_W-1:0];
            r_ey     <= ext_y[COORD_W-1:0];
            r_ez     <= ext_z[COORD_W-1:0];
            r_inside <= r_have &&
                        r_x >= r_min_x && r_y >= r_min_y && r_z >= r_min_z &&
                        r_x <= r_max_x && r_y <= r_max_y && r_z <= r_max_z;
        end
        if (r_state == ST_MAX) begin
            r_emax <= (r_ez > emax_xy) ? r_ez : emax_xy;
        end
        if (r_state == ST_READ) begin
            r_cell <= cell_q;
        end
        if (done_go) begin
            if (r_mode == MODE_CLEAR) begin
                r_out_overlap <= 1'b0;
                r_out_inside  <= 1'b0;
                r_out_cell    <= '0;
            end else begin
                r_out_overlap <= (r_mode == MODE_QUERY) && r_inside && ((r_row & col_bit) != '0);
                r_out_inside  <= r_inside;
                r_out_cell    <= INDEX_W'(r_cell);
            end
        end
    end

    // Cell map: one row of 16 cells per address, read-modify-write for marks.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SWEEP) begin
            r_map[r_sweep] <= '0;
        end else if (done_go && r_mode == MODE_MARK) begin
            r_map[cell_row] <= r_row | col_bit;
        end
        if (r_state == ST_READ) begin
            r_row <= r_map[cell_q[CELL_W-1:CELL_BITS]];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.overlap    = r_out_overlap;
    assign o_out.inside_box = r_out_inside;
    assign o_out.cell_index = r_out_cell;

    `VOG_ASSERT_NOW(a_overlap_inside, o_out.valid && o_out.overlap, o_out.inside_box,
        "overlap reported for a point outside the box")
    `VOG_ASSERT_NOW(a_box_ordered, r_have,
        r_min_x <= r_max_x && r_min_y <= r_max_y && r_min_z <= r_max_z,
        "bounding box minimum exceeds maximum")
    `VOG_ASSERT_NOW(a_empty_box_zero, !r_have,
        r_min_x == '0 && r_min_y == '0 && r_min_z == '0 &&
        r_max_x == '0 && r_max_y == '0 && r_max_z == '0,
        "box not zero while it holds no points")
    `VOG_ASSERT_NEXT(a_clear_sweeps, done_go && r_mode == MODE_CLEAR,
        r_state == ST_SWEEP && r_sweep == '0 && !r_have,
        "clear did not start a clearing pass")

endmodule

FILE: dv/voxel_occupancy_grid_tb.sv
// Self-checking testbench for the voxel occupancy grid: directed probes, then random episodes.
`timescale 1ns / 100ps

module voxel_occupancy_grid_tb
    import vog_pkg::*;
();

    localparam int RANDOM_ITEMS   = 1500;
    localparam int PHASE_ITEMS    = 100;
    localparam int IDLE_PERCENT   = 82;
    localparam int BOTH_PERCENT   = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT    = 100;
    localparam int NUM_PROBES     = 25;
    localparam int MARK_HISTORY   = 64;

    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_phase;

    typedef struct packed {
        logic               overlap;
        logic               inside_box;
        logic [INDEX_W-1:0] cell_index;
    } t_grid_result;

    typedef struct packed {
        t_mode        mode;
        logic [31:0]  x;
        logic [31:0]  y;
        logic [31:0]  z;
        logic         typed;
        t_grid_result result;
    } t_probe;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_point;

    localparam t_grid_result RES_NONE  = '0;
    localparam t_grid_result RES_ALONE = '{overlap: 1'b0, inside_box: 1'b1, cell_index: '0};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    vog_in_if  in_if ();
    vog_out_if out_if ();

    voxel_occupancy_grid u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Model of the grid state.
    longint box_lo [3];
    longint box_hi [3];
    bit     have_points;
    bit     occupied [1 << CELL_W];

    t_grid_result pending_results [$];
    t_point       marked_points [$];
    t_probe       probes [NUM_PROBES];
    t_idle_phase  idle_phase = IDLE_NONE;
    int           errors = 0;
    int           items_sent = 0;
    int           quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    function automatic void clear_grid();
        for (int i = 0; i < 3; i++) begin
            box_lo[i] = 0;
            box_hi[i] = 0;
        end
        have_points = 1'b0;
        for (int i = 0; i < (1 << CELL_W); i++) begin
            occupied[i] = 1'b0;
        end
    endfunction

    function automatic logic [CELL_BITS-1:0] axis_slot(longint c, longint lo, longint extent);
        longint offset;
        longint quot;
        offset = c - lo;
        if (extent <= 0 || offset <= 0) begin
            return '0;
        end
        quot = (offset <<< CELL_BITS) / extent;
        return (quot > longint'(CELL_TOP)) ? CELL_TOP : quot[CELL_BITS-1:0];
    endfunction

    // Applies one point to the grid state and returns the result it should produce.
    function automatic t_grid_result predict_grid(t_mode mode,
                                                  logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic signed [31:0] z);
        longint            pt [3];
        longint            extent;
        logic [CELL_W-1:0] slot;
        bit                in_box;
        t_grid_result      res;
        pt[0] = x;
        pt[1] = y;
        pt[2] = z;
        res = '0;
        if (mode == MODE_CLEAR) begin
            clear_grid();
            return res;
        end
        if (mode == MODE_WIDEN) begin
            for (int i = 0; i < 3; i++) begin
                if (!have_points || pt[i] < box_lo[i]) box_lo[i] = pt[i];
                if (!have_points || pt[i] > box_hi[i]) box_hi[i] = pt[i];
            end
            have_points = 1'b1;
        end
        extent = 0;
        in_box = have_points;
        for (int i = 0; i < 3; i++) begin
            if (box_hi[i] - box_lo[i] > extent) extent = box_hi[i] - box_lo[i];
            if (pt[i] < box_lo[i] || pt[i] > box_hi[i]) in_box = 1'b0;
        end
        slot = {axis_slot(pt[0], box_lo[0], extent),
                axis_slot(pt[1], box_lo[1], extent),
                axis_slot(pt[2], box_lo[2], extent)};
        if (mode == MODE_MARK) occupied[slot] = 1'b1;
        res.inside_box = in_box;
        res.cell_index = slot;
        res.overlap    = (mode == MODE_QUERY) && in_box && occupied[slot];
        return res;
    endfunction

    function automatic int sender_idle_pct();
        case (idle_phase)
            IDLE_SENDER: return IDLE_PERCENT;
            IDLE_BOTH:   return BOTH_PERCENT;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (idle_phase)
            IDLE_RECEIVER: return IDLE_PERCENT;
            IDLE_BOTH:     return BOTH_PERCENT;
            default:       return 0;
        endcase
    endfunction

    function automatic logic signed [31:0] clamp_coord(longint v);
        if (v < COORD_MIN) return COORD_MIN;
        if (v > COORD_MAX) return COORD_MAX;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] any_coord();
        return $urandom;
    endfunction

    function automatic logic signed [31:0] near_coord(longint center, int bits);
        longint off;
        off = longint'({$urandom, $urandom} & ((64'd1 << bits) - 1));
        if ($urandom_range(1)) off = -off;
        return clamp_coord(center + off);
    endfunction

    // Mostly inside the current box, with the inclusive edges and one step past them.
    function automatic logic signed [31:0] box_coord(int axis);
        longint span;
        span = box_hi[axis] - box_lo[axis] + 1;
        case ($urandom_range(7))
            0:       return clamp_coord(box_lo[axis]);
            1:       return clamp_coord(box_hi[axis]);
            2:       return clamp_coord(box_lo[axis] - 1);
            3:       return clamp_coord(box_hi[axis] + 1);
            default: return clamp_coord(box_lo[axis] + longint'({$urandom, $urandom} % span));
        endcase
    endfunction

    task automatic note_failure(string what);
        errors++;
        if (errors <= PRINT_LIMIT) $display("%0t: %s", $time, what);
    endtask

    task automatic send_point(t_mode mode,
                              logic signed [31:0] x,
                              logic signed [31:0] y,
                              logic signed [31:0] z,
                              bit typed = 1'b0,
                              t_grid_result typed_res = '0);
        int           gap;
        t_grid_result res;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct()) gap++;
        @(negedge i_clk);
        repeat (gap) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.mode    <= mode;
        in_if.x_coord <= x;
        in_if.y_coord <= y;
        in_if.z_coord <= z;
        do @(posedge i_clk); while (!in_if.ready);
        res = predict_grid(mode, x, y, z);
        pending_results.insert(pending_results.size(), typed ? typed_res : res);
        if (mode == MODE_CLEAR) marked_points.delete();
        if (mode == MODE_MARK) begin
            marked_points.insert(marked_points.size(), t_point'{x, y, z});
            if (marked_points.size() > MARK_HISTORY) void'(marked_points.pop_front());
        end
        items_sent++;
        idle_phase = t_idle_phase'((items_sent / PHASE_ITEMS) % 4);
    endtask

    // One episode: an optional clear, a cloud of widen points, then marks and queries
    // against that box, with a little noise mixed in.
    task automatic run_episode();
        int     n_widen;
        int     n_ops;
        int     bits;
        int     sel;
        longint cx;
        longint cy;
        longint cz;
        t_point p;
        t_mode  mode_pick;
        if ($urandom_range(7) == 0) send_point(MODE_CLEAR, any_coord(), any_coord(), any_coord());
        bits = $urandom_range(33);
        cx = near_coord(0, $urandom_range(33));
        cy = near_coord(0, $urandom_range(33));
        cz = near_coord(0, $urandom_range(33));
        n_widen = $urandom_range(1, 4);
        repeat (n_widen) begin
            send_point(MODE_WIDEN, near_coord(cx, bits), near_coord(cy, bits), near_coord(cz, bits));
        end
        n_ops = $urandom_range(4, 30);
        repeat (n_ops) begin
            sel = $urandom_range(99);
            if (sel < 35) begin
                send_point(MODE_MARK, box_coord(0), box_coord(1), box_coord(2));
            end else if (sel < 60 && marked_points.size() > 0) begin
                p = marked_points[$urandom_range(marked_points.size() - 1)];
                send_point(MODE_QUERY, p.x, p.y, p.z);
            end else if (sel < 85) begin
                send_point(MODE_QUERY, box_coord(0), box_coord(1), box_coord(2));
            end else if (sel < 92) begin
                send_point(MODE_WIDEN, near_coord(cx, bits + 1), near_coord(cy, bits + 1),
                           near_coord(cz, bits + 1));
            end else begin
                mode_pick = t_mode'($urandom_range(1, 3));
                if ($urandom_range(19) == 0) mode_pick = MODE_CLEAR;
                send_point(mode_pick, any_coord(), any_coord(), any_coord());
            end
        end
    endtask

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
    end

    // Result checker and progress counter, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_grid_result want;
        if (i_rst_n && ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("result transfer with nothing expected, cell %0d",
                                       out_if.cell_index));
            end else begin
                want = pending_results.pop_front();
                if (out_if.overlap !== want.overlap) begin
                    note_failure($sformatf("overlap %b, expected %b",
                                           out_if.overlap, want.overlap));
                end
                if (out_if.inside_box !== want.inside_box) begin
                    note_failure($sformatf("inside_box %b, expected %b",
                                           out_if.inside_box, want.inside_box));
                end
                if (out_if.cell_index !== want.cell_index) begin
                    note_failure($sformatf("cell_index %0d, expected %0d",
                                           out_if.cell_index, want.cell_index));
                end
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        in_if.valid   = 1'b0;
        in_if.mode    = MODE_CLEAR;
        in_if.x_coord = '0;
        in_if.y_coord = '0;
        in_if.z_coord = '0;
        out_if.ready  = 1'b0;
        clear_grid();
        probes = '{
            // Nothing marked and no box yet.
            '{MODE_QUERY, 32'd5, 32'd5, 32'd5, 1'b1, RES_NONE},
            // A mark before any widen point lands in cell 0 against the zero box.
            '{MODE_MARK, -32'sd7, 32'd100, 32'd3, 1'b1, RES_NONE},
            // Cell 0 is marked, but with no box the query still reports nothing.
            '{MODE_QUERY, 32'd0, 32'd0, 32'd0, 1'b1, RES_NONE},
            '{MODE_WIDEN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, RES_ALONE},
            '{MODE_WIDEN, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, RES_NONE},
            '{MODE_MARK, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, RES_NONE},
            '{MODE_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, RES_NONE},
            '{MODE_QUERY, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, RES_NONE},
            '{MODE_QUERY, 32'd0, 32'd0, 32'd0, 1'b0, RES_NONE},
            '{MODE_MARK, 32'd0, -32'sd1, 32'd1, 1'b0, RES_NONE},
            '{MODE_CLEAR, 32'd0, 32'd0, 32'd0, 1'b1, RES_NONE},
            '{MODE_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, RES_NONE},
            '{MODE_WIDEN, 32'd0, 32'd0, 32'd0, 1'b1, RES_ALONE},
            '{MODE_WIDEN, 32'd1000, 32'd10, -32'sd20, 1'b0, RES_NONE},
            '{MODE_MARK, 32'd500, 32'd5, -32'sd10, 1'b0, RES_NONE},
            '{MODE_QUERY, 32'd500, 32'd5, -32'sd10, 1'b0, RES_NONE},
            // Beyond the box on x, below it on y.
            '{MODE_QUERY, 32'd2000, -32'sd50, 32'd0, 1'b0, RES_NONE},
            '{MODE_MARK, 32'd2000, -32'sd50, 32'd0, 1'b0, RES_NONE},
            '{MODE_QUERY, 32'd1000, 32'd10, -32'sd20, 1'b0, RES_NONE},
            '{MODE_QUERY, 32'd1001, 32'd10, -32'sd20, 1'b0, RES_NONE},
            '{MODE_CLEAR, COORD_MAX, COORD_MIN, -32'sd1, 1'b1, RES_NONE},
            // A single-point box has zero extent, so every cell is 0.
            '{MODE_WIDEN, 32'd7, -32'sd7, 32'd7, 1'b1, RES_ALONE},
            '{MODE_MARK, 32'd7, -32'sd7, 32'd7, 1'b0, RES_NONE},
            '{MODE_QUERY, 32'd7, -32'sd7, 32'd7, 1'b0, RES_NONE},
            '{MODE_QUERY, 32'd6, -32'sd7, 32'd7, 1'b0, RES_NONE}
        };
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (probes[i]) begin
            send_point(probes[i].mode, probes[i].x, probes[i].y, probes[i].z,
                       probes[i].typed, probes[i].result);
        end
        while (items_sent < NUM_PROBES + RANDOM_ITEMS) run_episode();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/vog_pkg.sv
hw/rtl/vog_channels.sv
hw/rtl/vog_axis_div.sv
hw/rtl/voxel_occupancy_grid.sv
dv/voxel_occupancy_grid_tb.sv
